[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL files.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, cond, cons, msg) \
    `ASSERT_PROP(label, (cond) |-> (cons), msg)

`endif

[hw/rtl/mqttpp_pkg.sv]
package mqttpp_pkg;

    // Topic storage limits
    localparam int MAX_CHARS     = 32;
    localparam int TOPIC_CHARS_D = 32;

    localparam int LEN_W    = 28;
    localparam int TLEN_W   = 16;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_UP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUBSCRIBED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOPIC_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_A    = 3'd3;

    // Parser phases
    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TLEN_HI = 3'd2;
    localparam logic [2:0] PH_TLEN_LO = 3'd3;
    localparam logic [2:0] PH_TOPIC   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    // Status codes
    localparam logic [2:0] ST_DELIVERED   = 3'd0;
    localparam logic [2:0] ST_NOT_DELIV   = 3'd1;
    localparam logic [2:0] ST_PINGRESP    = 3'd2;
    localparam logic [2:0] ST_OTHER_TYPE  = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
    localparam logic [2:0] ST_NO_TOPIC_LEN = 3'd5;
    localparam logic [2:0] ST_TOPIC_OOB   = 3'd6;

    // Packet type codes
    localparam logic [3:0] KIND_PUBLISH  = 4'd3;
    localparam logic [3:0] KIND_PINGRESP = 4'd13;

    typedef struct packed {
        logic       link_up;
        logic       subscribed;
        logic [5:0] topic_length;
    } cfg_t;

    typedef struct packed {
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             payload_last;
        logic             done_valid;
        logic [2:0]       status;
        logic [LEN_W-1:0] payload_length;
    } result_t;

endpackage

[hw/rtl/mqttpp_cfg.sv]
module mqttpp_cfg #(
    parameter int TOPIC_CHARS = mqttpp_pkg::TOPIC_CHARS_D,
    localparam int STORE_CHARS = (TOPIC_CHARS < mqttpp_pkg::MAX_CHARS) ?
                                 TOPIC_CHARS : mqttpp_pkg::MAX_CHARS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mqttpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mqttpp_pkg::CFG_W-1:0]          cfg_data,
    output mqttpp_pkg::cfg_t                      cfg,
    output logic [STORE_CHARS-1:0][7:0]           chars
);

    mqttpp_pkg::cfg_t              cfg_reg;
    logic [STORE_CHARS-1:0][7:0]   chars_reg;

    // Scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mqttpp_pkg::REG_LINK_UP:    cfg_reg.link_up      <= cfg_data[0];
                mqttpp_pkg::REG_SUBSCRIBED: cfg_reg.subscribed   <= cfg_data[0];
                mqttpp_pkg::REG_TOPIC_LEN:  cfg_reg.topic_length <= cfg_data[5:0];
                default:                    ;
            endcase
        end
    end

    // Topic characters, eight to a register word, lowest byte first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
        end
        else
        begin
            for (int c = 0; c < STORE_CHARS; c++)
            begin
                if (cfg_we &&
                    cfg_index == mqttpp_pkg::CFG_IDX_W'(int'(mqttpp_pkg::REG_CHARS_A) + (c >> 3)))
                begin
                    chars_reg[c] <= cfg_data[8*(c & 7) +: 8];
                end
            end
        end
    end

    assign cfg   = cfg_reg;
    assign chars = chars_reg;

endmodule

[hw/rtl/mqttpp_parse.sv]
module mqttpp_parse #(
    parameter int TOPIC_CHARS = mqttpp_pkg::TOPIC_CHARS_D,
    localparam int STORE_CHARS = (TOPIC_CHARS < mqttpp_pkg::MAX_CHARS) ?
                                 TOPIC_CHARS : mqttpp_pkg::MAX_CHARS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [7:0]                    rx_byte,
    input  logic                          chunk_end,
    input  mqttpp_pkg::cfg_t              cfg,
    input  logic [STORE_CHARS-1:0][7:0]   chars,
    output logic                          present,
    output mqttpp_pkg::result_t           res
);

    localparam int LW    = mqttpp_pkg::LEN_W;
    localparam int TW    = mqttpp_pkg::TLEN_W;
    localparam int IDX_W = $clog2(STORE_CHARS);
    localparam logic [5:0] STORE_LEN = 6'(STORE_CHARS);

    logic [2:0]    phase_reg,   phase_next,   phase_upd;
    logic [LW-1:0] rem_reg,     rem_next,     rem_upd;
    logic [2:0]    lbc_reg,     lbc_next,     lbc_upd;
    logic [TW-1:0] tls_reg,     tls_next,     tls_upd;
    logic [TW-1:0] tidx_reg,    tidx_next,    tidx_upd;
    logic          match_reg,   match_next,   match_upd;
    logic [LW-1:0] target_reg,  target_next,  target_upd;
    logic [LW-1:0] count_reg,   count_next,   count_upd;
    logic [2:0]    pend_reg,    pend_next,    pend_upd;

    logic [5:0]    eff_len;
    logic [7:0]    cfg_char;
    logic [3:0]    kind;
    logic [1:0]    cnt;
    logic [LW-1:0] len_part;
    logic [TW-1:0] tls_full;
    logic [LW:0]   rem_m2;
    logic [TW-1:0] tidx_inc;
    logic [LW-1:0] count_inc;
    logic          match_chr;
    logic          pv;
    logic          plast;
    logic          active;

    // Configured character at the current topic position, zero past the length
    assign eff_len  = (cfg.topic_length < STORE_LEN) ? cfg.topic_length : STORE_LEN;
    assign cfg_char = (tidx_reg < TW'(eff_len)) ? chars[tidx_reg[IDX_W-1:0]] : 8'd0;

    assign kind      = rx_byte[7:4];
    assign cnt       = lbc_reg[1:0];
    assign len_part  = LW'(rx_byte[6:0]) << (5'(cnt) * 5'd7);
    assign tls_full  = {tls_reg[15:8], rx_byte};
    assign rem_m2    = {1'b0, rem_reg} - (LW+1)'(2);
    assign tidx_inc  = tidx_reg + TW'(1);
    assign count_inc = count_reg + LW'(1);
    assign match_chr = (rx_byte == cfg_char);
    assign active    = step && cfg.link_up;

    // Advance the parser by one byte
    always_comb
    begin
        phase_upd  = phase_reg;
        rem_upd    = rem_reg;
        lbc_upd    = lbc_reg;
        tls_upd    = tls_reg;
        tidx_upd   = tidx_reg;
        match_upd  = match_reg;
        target_upd = target_reg;
        count_upd  = count_reg;
        pend_upd   = pend_reg;
        pv         = 1'b0;
        plast      = 1'b0;

        unique case (phase_reg)
            mqttpp_pkg::PH_TYPE:
            begin
                if (kind == mqttpp_pkg::KIND_PUBLISH)
                begin
                    phase_upd = mqttpp_pkg::PH_LEN;
                    rem_upd   = '0;
                    lbc_upd   = '0;
                    pend_upd  = mqttpp_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    phase_upd = mqttpp_pkg::PH_SKIP;
                    pend_upd  = (kind == mqttpp_pkg::KIND_PINGRESP) ?
                                mqttpp_pkg::ST_PINGRESP : mqttpp_pkg::ST_OTHER_TYPE;
                end
            end
            mqttpp_pkg::PH_LEN:
            begin
                rem_upd = rem_reg + len_part;
                lbc_upd = {1'b0, cnt} + 3'd1;
                if (rx_byte[7])
                begin
                    pend_upd = mqttpp_pkg::ST_BAD_LENGTH;
                    if (lbc_upd[2])
                    begin
                        phase_upd = mqttpp_pkg::PH_SKIP;
                    end
                end
                else
                begin
                    phase_upd = mqttpp_pkg::PH_TLEN_HI;
                    pend_upd  = mqttpp_pkg::ST_NO_TOPIC_LEN;
                end
            end
            mqttpp_pkg::PH_TLEN_HI:
            begin
                tls_upd   = {rx_byte, 8'd0};
                phase_upd = mqttpp_pkg::PH_TLEN_LO;
                pend_upd  = mqttpp_pkg::ST_NO_TOPIC_LEN;
            end
            mqttpp_pkg::PH_TLEN_LO:
            begin
                tls_upd = tls_full;
                if (rem_m2[LW] || (LW'(tls_full) > rem_m2[LW-1:0]))
                begin
                    pend_upd  = mqttpp_pkg::ST_TOPIC_OOB;
                    phase_upd = mqttpp_pkg::PH_SKIP;
                end
                else
                begin
                    target_upd = rem_m2[LW-1:0] - LW'(tls_full);
                    count_upd  = '0;
                    tidx_upd   = '0;
                    if (tls_full == '0)
                    begin
                        match_upd = cfg.subscribed;
                        pend_upd  = cfg.subscribed ? mqttpp_pkg::ST_DELIVERED :
                                                     mqttpp_pkg::ST_NOT_DELIV;
                        phase_upd = mqttpp_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        match_upd = 1'b1;
                        phase_upd = mqttpp_pkg::PH_TOPIC;
                        pend_upd  = mqttpp_pkg::ST_TOPIC_OOB;
                    end
                end
            end
            mqttpp_pkg::PH_TOPIC:
            begin
                match_upd = match_reg && match_chr;
                tidx_upd  = tidx_inc;
                if (tidx_inc >= tls_reg)
                begin
                    match_upd = match_reg && match_chr && cfg.subscribed;
                    pend_upd  = match_upd ? mqttpp_pkg::ST_DELIVERED :
                                            mqttpp_pkg::ST_NOT_DELIV;
                    phase_upd = mqttpp_pkg::PH_PAYLOAD;
                end
            end
            mqttpp_pkg::PH_PAYLOAD:
            begin
                if (count_reg < target_reg)
                begin
                    count_upd = count_inc;
                    if (match_reg)
                    begin
                        pv    = 1'b1;
                        plast = chunk_end || (count_inc == target_reg);
                    end
                end
            end
            default:
            begin
                // Skip until the chunk ends
            end
        endcase
    end

    // Form the result of this byte
    always_comb
    begin
        present            = active && (pv || chunk_end);
        res.payload_valid  = pv;
        res.payload_byte   = pv ? rx_byte : 8'd0;
        res.payload_last   = plast;
        res.done_valid     = chunk_end;
        res.status         = chunk_end ? pend_upd : 3'd0;
        res.payload_length = (chunk_end && phase_upd == mqttpp_pkg::PH_PAYLOAD && match_upd) ?
                             count_upd : '0;
    end

    // Hold, advance, or clear at the end of a chunk
    always_comb
    begin
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        lbc_next    = lbc_reg;
        tls_next    = tls_reg;
        tidx_next   = tidx_reg;
        match_next  = match_reg;
        target_next = target_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        if (active)
        begin
            if (chunk_end)
            begin
                phase_next  = mqttpp_pkg::PH_TYPE;
                rem_next    = '0;
                lbc_next    = '0;
                tls_next    = '0;
                tidx_next   = '0;
                match_next  = 1'b1;
                target_next = '0;
                count_next  = '0;
                pend_next   = '0;
            end
            else
            begin
                phase_next  = phase_upd;
                rem_next    = rem_upd;
                lbc_next    = lbc_upd;
                tls_next    = tls_upd;
                tidx_next   = tidx_upd;
                match_next  = match_upd;
                target_next = target_upd;
                count_next  = count_upd;
                pend_next   = pend_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mqttpp_pkg::PH_TYPE;
            rem_reg    <= '0;
            lbc_reg    <= '0;
            tls_reg    <= '0;
            tidx_reg   <= '0;
            match_reg  <= 1'b1;
            target_reg <= '0;
            count_reg  <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rem_reg    <= rem_next;
            lbc_reg    <= lbc_next;
            tls_reg    <= tls_next;
            tidx_reg   <= tidx_next;
            match_reg  <= match_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

[hw/rtl/mqttpp_out.sv]
module mqttpp_out (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  mqttpp_pkg::result_t   res,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output mqttpp_pkg::result_t   held,
    output logic                  free
);

    logic                 valid_reg, valid_next;
    mqttpp_pkg::result_t  data_reg;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = data_reg;

endmodule

[hw/rtl/mqtt_publish_packet_parser_core.sv]
// MQTT PUBLISH packet parser.
// Input stream (s_*): one received byte per transfer, s_tlast on the last byte
// of a chunk; each chunk is parsed as one MQTT packet.
// Output stream (m_*): at most one result per input byte. A result is either a
// delivered payload byte (m_tuser[0]) or the chunk's closing status
// (m_tuser[1]), or both on the chunk's last byte. m_tlast marks the last
// delivered payload byte of the packet.
// Configuration (cfg_we, cfg_index, cfg_data): link_up, subscribed,
// topic_length and four words of topic characters; write only while idle.
// Each byte sits in the input register, and the parser result loads the result
// register when it is free. Throughput: one byte per cycle while the result
// register is free, since every byte is one pass through the parser logic.
// Reset clears the parser to wait for a type byte, clears all configuration
// and empties both registers. When m_tready is low with a result held, the
// input register still takes one more byte, then s_tready drops until the
// result is taken.
module mqtt_publish_packet_parser_core #(
    parameter int TOPIC_CHARS = mqttpp_pkg::TOPIC_CHARS_D
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] rx_byte
    input  logic                              s_tlast,   // chunk_end
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [7:0] payload_byte, [10:8] status, [38:11] payload_length, [39] zero
    output logic [39:0]                       m_tdata,
    output logic [1:0]                        m_tuser,   // [0] payload_valid, [1] done_valid
    output logic                              m_tlast,   // payload_last
    input  logic                              cfg_we,
    input  logic [mqttpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mqttpp_pkg::CFG_W-1:0]      cfg_data
);

    localparam int STORE_CHARS = (TOPIC_CHARS < mqttpp_pkg::MAX_CHARS) ?
                                 TOPIC_CHARS : mqttpp_pkg::MAX_CHARS;

    logic                         in_valid_reg, in_valid_next;
    logic [7:0]                   in_byte_reg;
    logic                         in_last_reg;
    logic                         out_free;
    logic                         step;
    logic                         present;
    mqttpp_pkg::cfg_t             cfg;
    logic [STORE_CHARS-1:0][7:0]  chars;
    mqttpp_pkg::result_t          res;
    mqttpp_pkg::result_t          held;

    // Input register: fill when empty and refill whenever its byte moves on
    assign s_tready = !in_valid_reg || out_free;
    assign step     = in_valid_reg && out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    mqttpp_cfg #(
        .TOPIC_CHARS (TOPIC_CHARS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .chars     (chars)
    );

    mqttpp_parse #(
        .TOPIC_CHARS (TOPIC_CHARS)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .chunk_end (in_last_reg),
        .cfg       (cfg),
        .chars     (chars),
        .present   (present),
        .res       (res)
    );

    mqttpp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (present),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .held     (held),
        .free     (out_free)
    );

    // Pack the result fields
    assign m_tdata = {1'b0, held.payload_length, held.status, held.payload_byte};
    assign m_tuser = {held.done_valid, held.payload_valid};
    assign m_tlast = held.payload_last;

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_last_has_byte, m_tvalid && m_tlast, m_tuser[0],
        "payload_last without a payload byte")
    `ASSERT_IMPLIES(a_result_kind, m_tvalid, m_tuser != 2'b00,
        "result carries neither payload nor status")
    `ASSERT_IMPLIES(a_status_only_done, m_tvalid && !m_tuser[1], m_tdata[38:8] == '0,
        "status fields set without done_valid")
    `ASSERT_IMPLIES(a_stall_source, !s_tready, m_tvalid && !m_tready && in_valid_reg,
        "input stalled while the result register can drain")

endmodule

[tb/tb_mqtt_publish_packet_parser_core.sv]
module tb_mqtt_publish_packet_parser_core;

    typedef logic [7:0] byte_q_t[$];

    localparam int CLK_PERIOD = 10;
    localparam int TOPIC_CAP  = mqttpp_pkg::TOPIC_CHARS_D;
    localparam int SETTLE     = 12;
    localparam int ITEMS_TOTAL = 450;
    localparam int RUN_LIMIT  = 2_000_000;
    localparam logic [27:0] MAX_REM = 28'hFFFFFFF;

    localparam logic [mqttpp_pkg::CFG_IDX_W-1:0] REG_CHARS_B = mqttpp_pkg::REG_CHARS_A + 3'd1;
    localparam logic [mqttpp_pkg::CFG_IDX_W-1:0] REG_CHARS_C = mqttpp_pkg::REG_CHARS_A + 3'd2;
    localparam logic [mqttpp_pkg::CFG_IDX_W-1:0] REG_CHARS_D = mqttpp_pkg::REG_CHARS_A + 3'd3;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [7:0]                       s_tdata;
    logic                             s_tlast;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [39:0]                      m_tdata;
    logic [1:0]                       m_tuser;
    logic                             m_tlast;
    logic                             cfg_we;
    logic [mqttpp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mqttpp_pkg::CFG_W-1:0]     cfg_data;

    // Shadow copy of the configuration registers
    logic        cfg_link;
    logic        cfg_sub;
    logic [5:0]  cfg_tlen;
    logic [63:0] cfg_chars [4];

    // Shadow copy of the parser state
    logic [2:0]  ph;
    logic [3:0]  kind;
    logic [27:0] rem;
    logic [2:0]  lcnt;
    logic [15:0] tlen;
    logic [15:0] tidx;
    logic        tmatch;
    logic [27:0] ptarget;
    logic [27:0] pcount;
    logic [2:0]  pstat;

    mqttpp_pkg::result_t packet_results_q[$];

    int  fail_count;
    int  mismatch_count;
    int  accepted_bytes;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  rx_stall;
    int  rx_hold_left;

    mqtt_publish_packet_parser_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Configured topic character, zero at or beyond the configured length
    function automatic logic [7:0] topic_char(input logic [15:0] idx);
        int unsigned len;
        logic [63:0] word;
        len = cfg_tlen;
        if (len > TOPIC_CAP) len = TOPIC_CAP;
        if (len > 32) len = 32;
        if (idx >= len) return 8'h00;
        word = cfg_chars[idx[4:3]];
        return word[idx[2:0]*8 +: 8];
    endfunction

    function automatic void clear_parse();
        ph      = mqttpp_pkg::PH_TYPE;
        kind    = '0;
        rem     = '0;
        lcnt    = '0;
        tlen    = '0;
        tidx    = '0;
        tmatch  = 1'b1;
        ptarget = '0;
        pcount  = '0;
        pstat   = '0;
    endfunction

    // Take the delivery decision once the topic is complete
    function automatic void close_topic();
        tmatch = tmatch && cfg_sub;
        pstat  = tmatch ? mqttpp_pkg::ST_DELIVERED : mqttpp_pkg::ST_NOT_DELIV;
        ph     = mqttpp_pkg::PH_PAYLOAD;
    endfunction

    // Advance the parser by one byte and queue the result it causes
    function automatic void parse_byte(input logic [7:0] b, input logic last_b);
        mqttpp_pkg::result_t r;
        logic                pv;
        logic                plast;
        logic [1:0]          cnt;
        logic [31:0]         shifted;
        pv    = 1'b0;
        plast = 1'b0;
        r     = '0;
        if (!cfg_link) return;
        case (ph)
            mqttpp_pkg::PH_TYPE:
            begin
                kind = b[7:4];
                if (kind == mqttpp_pkg::KIND_PUBLISH)
                begin
                    ph    = mqttpp_pkg::PH_LEN;
                    rem   = '0;
                    lcnt  = '0;
                    pstat = mqttpp_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    ph    = mqttpp_pkg::PH_SKIP;
                    pstat = (kind == mqttpp_pkg::KIND_PINGRESP) ?
                            mqttpp_pkg::ST_PINGRESP : mqttpp_pkg::ST_OTHER_TYPE;
                end
            end
            mqttpp_pkg::PH_LEN:
            begin
                cnt     = lcnt[1:0];
                shifted = {25'd0, b[6:0]} << (7 * cnt);
                rem     = rem + shifted[27:0];
                lcnt    = {1'b0, cnt} + 3'd1;
                if (b[7])
                begin
                    pstat = mqttpp_pkg::ST_BAD_LENGTH;
                    if (lcnt >= 3'd4) ph = mqttpp_pkg::PH_SKIP;
                end
                else
                begin
                    ph    = mqttpp_pkg::PH_TLEN_HI;
                    pstat = mqttpp_pkg::ST_NO_TOPIC_LEN;
                end
            end
            mqttpp_pkg::PH_TLEN_HI:
            begin
                tlen  = {b, 8'h00};
                ph    = mqttpp_pkg::PH_TLEN_LO;
                pstat = mqttpp_pkg::ST_NO_TOPIC_LEN;
            end
            mqttpp_pkg::PH_TLEN_LO:
            begin
                tlen = tlen | {8'h00, b};
                if (rem < 28'd2 || {12'd0, tlen} > rem - 28'd2)
                begin
                    pstat = mqttpp_pkg::ST_TOPIC_OOB;
                    ph    = mqttpp_pkg::PH_SKIP;
                end
                else
                begin
                    ptarget = rem - 28'd2 - {12'd0, tlen};
                    pcount  = '0;
                    tidx    = '0;
                    tmatch  = 1'b1;
                    if (tlen == 16'd0)
                    begin
                        close_topic();
                    end
                    else
                    begin
                        ph    = mqttpp_pkg::PH_TOPIC;
                        pstat = mqttpp_pkg::ST_TOPIC_OOB;
                    end
                end
            end
            mqttpp_pkg::PH_TOPIC:
            begin
                if (b != topic_char(tidx)) tmatch = 1'b0;
                tidx = tidx + 16'd1;
                if (tidx >= tlen) close_topic();
            end
            mqttpp_pkg::PH_PAYLOAD:
            begin
                if (pcount < ptarget)
                begin
                    pcount = pcount + 28'd1;
                    if (tmatch)
                    begin
                        pv    = 1'b1;
                        plast = last_b || (pcount == ptarget);
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (!pv && !last_b) return;
        r.payload_valid = pv;
        r.payload_byte  = pv ? b : 8'h00;
        r.payload_last  = plast;
        if (last_b)
        begin
            r.done_valid     = 1'b1;
            r.status         = pstat;
            r.payload_length = (ph == mqttpp_pkg::PH_PAYLOAD && tmatch) ? pcount : '0;
            clear_parse();
        end
        packet_results_q.push_back(r);
    endfunction

    function automatic byte_q_t cfg_topic(input int unsigned n);
        byte_q_t q;
        for (int unsigned i = 0; i < n; i++) q.push_back(topic_char(16'(i)));
        return q;
    endfunction

    function automatic byte_q_t rand_bytes(input int unsigned n);
        byte_q_t q;
        for (int unsigned i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // Type byte, variable remaining length, topic length, then the body
    function automatic byte_q_t publish_bytes(input logic [3:0] flags,
                                              input int unsigned rem_len,
                                              input logic [15:0] tl,
                                              input byte_q_t body);
        byte_q_t     p;
        int unsigned r;
        logic [7:0]  d;
        r = rem_len;
        p.push_back({mqttpp_pkg::KIND_PUBLISH, flags});
        do
        begin
            d = 8'(r % 128);
            r = r / 128;
            if (r != 0) d[7] = 1'b1;
            p.push_back(d);
        end
        while (r != 0);
        p.push_back(tl[15:8]);
        p.push_back(tl[7:0]);
        foreach (body[i]) p.push_back(body[i]);
        return p;
    endfunction

    // Write one configuration register and its shadow copy
    task automatic write_reg(input logic [mqttpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            mqttpp_pkg::REG_LINK_UP:    cfg_link = value[0];
            mqttpp_pkg::REG_SUBSCRIBED: cfg_sub  = value[0];
            mqttpp_pkg::REG_TOPIC_LEN:  cfg_tlen = value[5:0];
            mqttpp_pkg::REG_CHARS_A:    cfg_chars[0] = value;
            REG_CHARS_B:                cfg_chars[1] = value;
            REG_CHARS_C:                cfg_chars[2] = value;
            REG_CHARS_D:                cfg_chars[3] = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Flag registers get random upper bits, which the block must drop
    task automatic set_flags(input logic link, input logic sub);
        write_reg(mqttpp_pkg::REG_LINK_UP, {$urandom, $urandom} & ~64'h1 | {63'd0, link});
        write_reg(mqttpp_pkg::REG_SUBSCRIBED, {$urandom, $urandom} & ~64'h1 | {63'd0, sub});
    endtask

    task automatic set_topic(input logic [5:0] len, input logic [63:0] a, input logic [63:0] b,
                             input logic [63:0] c, input logic [63:0] d);
        write_reg(mqttpp_pkg::REG_TOPIC_LEN, {$urandom, $urandom} & ~64'h3F | {58'd0, len});
        write_reg(mqttpp_pkg::REG_CHARS_A, a);
        write_reg(REG_CHARS_B, b);
        write_reg(REG_CHARS_C, c);
        write_reg(REG_CHARS_D, d);
    endtask

    // Offer one byte after a random gap and wait for its transfer
    task automatic send_byte(input logic [7:0] b, input logic last_b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last_b;
        do @(posedge clk); while (!s_tready);
        if (cfg_link) accepted_bytes++;
        parse_byte(b, last_b);
    endtask

    task automatic send_chunk(input byte_q_t bytes);
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Stop offering, let every queued result arrive, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (packet_results_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_link_down();
        byte_q_t pkt;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // Link is down after reset: every byte is dropped
        pkt = '{8'h30, 8'h05, 8'h00, 8'h00, 8'hAA, 8'h55};
        send_chunk(pkt);
        pkt = '{8'hD0};
        send_chunk(pkt);
        wait_drained();
        set_flags(1'b0, 1'b1);
        pkt = '{8'hFF, 8'h00};
        send_chunk(pkt);
        wait_drained();
    endtask

    task automatic test_directed();
        byte_q_t pkt;
        byte_q_t body;
        set_topic(6'd8, 64'h3064_6D63_2F76_6564, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        set_flags(1'b1, 1'b1);
        // Non-publish types
        pkt = '{8'hD0};
        send_chunk(pkt);
        pkt = '{8'h00};
        send_chunk(pkt);
        pkt = '{8'hF5, 8'hFF, 8'h00};
        send_chunk(pkt);
        // Publish type byte alone, truncated length, overlong length
        pkt = '{8'h30};
        send_chunk(pkt);
        pkt = '{8'h3F, 8'h80};
        send_chunk(pkt);
        pkt = '{8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h02};
        send_chunk(pkt);
        // Topic length missing or half there
        pkt = '{8'h30, 8'h05};
        send_chunk(pkt);
        pkt = '{8'h30, 8'h05, 8'h00};
        send_chunk(pkt);
        // Remaining below two, topic past remaining
        pkt = '{8'h30, 8'h01, 8'h00, 8'h00, 8'hAA};
        send_chunk(pkt);
        pkt = '{8'h30, 8'h00, 8'h00, 8'h00};
        send_chunk(pkt);
        pkt = '{8'h30, 8'h04, 8'h00, 8'h03, 8'h61, 8'h62};
        send_chunk(pkt);
        // Chunk ends inside the topic
        body = cfg_topic(4);
        pkt = publish_bytes(4'h0, 13, 16'd8, body);
        send_chunk(pkt);
        // Empty topic with payload, then empty topic and empty payload
        body = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        pkt = publish_bytes(4'h2, 6, 16'd0, body);
        send_chunk(pkt);
        body.delete();
        pkt = publish_bytes(4'h0, 2, 16'd0, body);
        send_chunk(pkt);
        // Matching topic, chunk longer than the packet
        body = {cfg_topic(8), rand_bytes(3), rand_bytes(4)};
        pkt = publish_bytes(4'h1, 13, 16'd8, body);
        send_chunk(pkt);
        // Remaining far beyond the chunk: payload clamped at chunk end
        body = {cfg_topic(8), rand_bytes(5)};
        pkt = publish_bytes(4'hB, 210, 16'd8, body);
        send_chunk(pkt);
        // Topic longer than configured: zero tail matches, other tail does not
        body = {cfg_topic(10), rand_bytes(2)};
        pkt = publish_bytes(4'h0, 14, 16'd10, body);
        send_chunk(pkt);
        body = {cfg_topic(8), 8'h41, 8'h00, rand_bytes(2)};
        pkt = publish_bytes(4'h0, 14, 16'd10, body);
        send_chunk(pkt);
        // Wrong topic character
        body = {cfg_topic(7), 8'h7E, rand_bytes(2)};
        pkt = publish_bytes(4'h0, 12, 16'd8, body);
        send_chunk(pkt);
        wait_drained();
        // Matching topic while not subscribed
        set_flags(1'b1, 1'b0);
        body = {cfg_topic(8), rand_bytes(3)};
        pkt = publish_bytes(4'h0, 13, 16'd8, body);
        send_chunk(pkt);
        wait_drained();
    endtask

    task automatic test_topic_extremes();
        byte_q_t pkt;
        byte_q_t body;
        set_flags(1'b1, 1'b1);
        // No configured topic: only zero characters match
        set_topic(6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        body = '{8'h00, 8'h00, 8'h11, 8'h22};
        pkt = publish_bytes(4'h0, 6, 16'd2, body);
        send_chunk(pkt);
        body = '{8'h01, 8'h11};
        pkt = publish_bytes(4'h0, 4, 16'd1, body);
        send_chunk(pkt);
        wait_drained();
        // Full 32-character topic of all ones, then a length clamped to 32
        set_topic(6'd32, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        body = {cfg_topic(32), rand_bytes(3)};
        pkt = publish_bytes(4'h0, 37, 16'd32, body);
        send_chunk(pkt);
        wait_drained();
        set_topic(6'd63, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        body = {cfg_topic(34), rand_bytes(2)};
        pkt = publish_bytes(4'h0, 38, 16'd34, body);
        send_chunk(pkt);
        body = {cfg_topic(32), 8'hFF, rand_bytes(2)};
        pkt = publish_bytes(4'h0, 37, 16'd33, body);
        send_chunk(pkt);
        wait_drained();
        set_topic(6'd31, 64'd0, 64'd0, 64'd0, 64'd0);
        body = {cfg_topic(31), rand_bytes(2)};
        pkt = publish_bytes(4'h0, 35, 16'd31, body);
        send_chunk(pkt);
        wait_drained();
    endtask

    task automatic send_random_publish();
        byte_q_t     topic;
        byte_q_t     payload;
        byte_q_t     pkt;
        int unsigned eff;
        int unsigned tl;
        int unsigned n;
        int unsigned rem_len;
        int unsigned cut;
        eff = (cfg_tlen > TOPIC_CAP) ? TOPIC_CAP : cfg_tlen;
        tl = $urandom_range(0, eff + 2);
        topic = cfg_topic(tl);
        if (tl > 0 && $urandom_range(0, 2) == 0)
        begin
            topic[$urandom_range(0, tl - 1)] ^= 8'($urandom_range(1, 255));
        end
        n = $urandom_range(0, 12);
        payload = rand_bytes(n);
        case ($urandom_range(0, 5))
            0, 1, 2: rem_len = 2 + tl + n;
            3:       rem_len = 2 + tl + n + $urandom_range(1, 400);
            4:       rem_len = $urandom_range(2 + tl + n, MAX_REM);
            default: rem_len = 2 + tl + $urandom_range(0, n);
        endcase
        // Broken length fields: topic past remaining or random wide values
        case ($urandom_range(0, 19))
            0, 1:    rem_len = (tl > 0) ? tl + 1 : $urandom_range(0, 1);
            2:
            begin
                tl = $urandom_range(0, 65535);
                rem_len = $urandom_range(0, MAX_REM);
            end
            default:
            begin
            end
        endcase
        pkt = publish_bytes(4'($urandom_range(0, 15)), rem_len, 16'(tl), {topic, payload});
        if ($urandom_range(0, 9) == 0)
        begin
            cut = $urandom_range(1, pkt.size());
            pkt = pkt[0:cut-1];
        end
        send_chunk(pkt);
    endtask

    task automatic reconfigure_random();
        logic [5:0] len;
        case ($urandom_range(0, 7))
            0:       len = 6'd0;
            1:       len = 6'd32;
            2:       len = 6'd63;
            3:       len = 6'd1;
            default: len = 6'($urandom_range(0, 63));
        endcase
        if ($urandom_range(0, 5) == 0)
        begin
            set_topic(len, 64'd0, 64'd0, 64'd0, 64'd0);
        end
        else
        begin
            set_topic(len, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
        end
        set_flags($urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0);
    endtask

    // Random chunks until the whole run has sent about the planned item count
    task automatic test_random_traffic();
        do
        begin
            reconfigure_random();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 10; k++)
            begin
                if (k >= 4 && accepted_bytes >= ITEMS_TOTAL) break;
                if ($urandom_range(0, 3) != 0) send_random_publish();
                else send_chunk(rand_bytes($urandom_range(1, 8)));
            end
            wait_drained();
        end
        while (accepted_bytes < ITEMS_TOTAL);
    endtask

    task automatic test_backpressure();
        byte_q_t body;
        byte_q_t pkt;
        set_topic(6'd8, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
        set_flags(1'b1, 1'b1);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        // Hold the result side while the sender keeps offering
        rx_hold_left = 150;
        repeat (3)
        begin
            body = {cfg_topic(8), rand_bytes(16)};
            pkt = publish_bytes(4'h0, 26, 16'd8, body);
            send_chunk(pkt);
        end
        // Pause until all results are in, then resume with idling
        wait_drained();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        body = {cfg_topic(8), rand_bytes(6)};
        pkt = publish_bytes(4'h0, 16, 16'd8, body);
        send_chunk(pkt);
        wait_drained();
    endtask

    task automatic show_result(input string tag, input mqttpp_pkg::result_t r);
        $display("  %s: pv=%0d byte=%h last=%0d done=%0d status=%0d len=%0d", tag,
                 r.payload_valid, r.payload_byte, r.payload_last, r.done_valid,
                 r.status, r.payload_length);
    endtask

    // Check every result transfer against the oldest queued result
    always @(posedge clk)
    begin
        mqttpp_pkg::result_t seen;
        mqttpp_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.payload_valid  = m_tuser[0];
            seen.payload_byte   = m_tdata[7:0];
            seen.payload_last   = m_tlast;
            seen.done_valid     = m_tuser[1];
            seen.status         = m_tdata[10:8];
            seen.payload_length = m_tdata[38:11];
            rx_stall = rx_idle_on ? $urandom_range(0, 11) : 0;
            if (packet_results_q.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Unexpected result transfer");
                    show_result("actual", seen);
                end
            end
            else
            begin
                want = packet_results_q.pop_front();
                if (seen !== want)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Result mismatch");
                        show_result("expected", want);
                        show_result("actual", seen);
                    end
                end
            end
        end
    end

    // Drive the result-side ready: long hold first, then per-result stalls
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int spin;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        cfg_link     = 1'b0;
        cfg_sub      = 1'b0;
        cfg_tlen     = '0;
        foreach (cfg_chars[i]) cfg_chars[i] = '0;
        fail_count     = 0;
        mismatch_count = 0;
        accepted_bytes = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_stall       = 0;
        rx_hold_left   = 0;
        clear_parse();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_link_down();
        test_directed();
        test_topic_extremes();
        test_backpressure();
        test_random_traffic();

        // Final drain with a bound, then settle
        @(negedge clk);
        s_tvalid <= 1'b0;
        spin = 0;
        while (packet_results_q.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        if (packet_results_q.size() != 0)
        begin
            fail_count++;
            $display("%0d results never arrived", packet_results_q.size());
        end
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mqttpp_pkg.sv
hw/rtl/mqttpp_cfg.sv
hw/rtl/mqttpp_parse.sv
hw/rtl/mqttpp_out.sv
hw/rtl/mqtt_publish_packet_parser_core.sv
tb/tb_mqtt_publish_packet_parser_core.sv
